@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clk edge, disabled while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/okst_pkg.sv @@
// ----------------------------------------------------------------------------
// okst_pkg
// Types and constants for the ordered key set table.
// ----------------------------------------------------------------------------
package okst_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 16;

    // Width of a stored key.
    localparam int KEY_W = 32;

    // Width of the reported count field.
    localparam int CNT_W = 5;

    // Width of the read position field.
    localparam int POS_W = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic                    found;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] read_value;
        status_t                 status;
    } rsp_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic add_en;
        logic rem_en;
    } cell_ctl_t;

endpackage

@@ hw/rtl/okst_cell.sv @@
// ----------------------------------------------------------------------------
// okst_cell
// One table slot: holds a key, compares it, and takes its neighbor's key on
// a remove that falls at or below this slot.
// ----------------------------------------------------------------------------
module okst_cell
    import okst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
)
(
    input  logic                       clk,
    input  cell_ctl_t                  ctl,
    input  logic [KEY_W-1:0]           key,
    input  logic [$clog2(DEPTH+1)-1:0] used,
    input  logic [$clog2(DEPTH)-1:0]   hit_idx,
    input  logic [KEY_W-1:0]           next_data,
    output logic [KEY_W-1:0]           data,
    output logic                       match
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);
    localparam logic [CntW-1:0] MY_CNT = CntW'(IDX);
    localparam logic [IdxW-1:0] MY_POS = IdxW'(IDX);

    logic [KEY_W-1:0] data_reg;
    logic [KEY_W-1:0] data_next;
    logic             match_reg;
    logic             match_next;

    // Compare against the incoming key; only occupied slots can hit
    always_comb
    begin
        match_next = match_reg;
        if (ctl.cmp_en)
        begin
            match_next = (MY_CNT < used) && (data_reg == key);
        end
    end

    // Append into the first free slot, or close the gap left by a remove
    always_comb
    begin
        data_next = data_reg;
        if (ctl.add_en && (MY_CNT == used))
        begin
            data_next = key;
        end
        else if (ctl.rem_en && (MY_POS >= hit_idx))
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ hw/rtl/okst_hit_enc.sv @@
// ----------------------------------------------------------------------------
// okst_hit_enc
// Registered one-hot to index encoder over the cell match bits.
// ----------------------------------------------------------------------------
module okst_hit_enc
    import okst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic [DEPTH-1:0]         match,
    output logic                     found,
    output logic [$clog2(DEPTH)-1:0] hit_idx
);

    localparam int IdxW = $clog2(DEPTH);

    logic            found_reg;
    logic            found_next;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] idx_next;

    // OR the matches; keys are distinct so at most one bit is set
    always_comb
    begin
        found_next = 1'b0;
        idx_next   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found_next = found_next | match[i];
            idx_next   = idx_next | (match[i] ? IdxW'(i) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        idx_reg   <= idx_next;
    end

    assign found   = found_reg;
    assign hit_idx = idx_reg;

endmodule

@@ hw/rtl/ordered_key_set_table_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_key_set_table_unit
// Ordered set of distinct 32-bit keys held in a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Each item passes through S_IDLE, S_ENC and S_APPLY: the cells compare the
// key at the accepting edge, the encoder registers the match bits in S_ENC,
// and the cells update at the end of S_APPLY, with the result strobed on done
// in the cycle after that. busy is high in S_ENC and S_APPLY, so the next item
// may start in the very cycle the previous result is shown. Results are shown
// on rsp for exactly one cycle while done is high and cannot be held off.
// Nothing needs clearing after reset: slots above the count are never read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_key_set_table_unit
    import okst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);
    localparam int PW   = IdxW + CntW + POS_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ENC   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CntW-1:0]  used_reg;
    logic [CntW-1:0]  used_next;
    logic             done_reg;
    logic             done_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [POS_W-1:0] pos_reg;

    logic             accept;
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] cell_key;
    logic [KEY_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic             hit_found;
    logic [IdxW-1:0]  hit_idx;
    logic             full;
    logic [PW-1:0]    pos_wide;
    logic [PW-1:0]    used_wide;
    logic [PW-1:0]    cnt_wide;
    logic             pos_ok;
    logic [KEY_W-1:0] rd_data;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Feed the live key while idle, the held key afterwards
    assign cell_key = (state_reg == S_IDLE) ? cmd.key : key_reg;

    // Broadcast controls
    assign full       = (used_reg == CntW'(DEPTH));
    assign ctl.cmp_en = accept;
    assign ctl.add_en = (state_reg == S_APPLY) && (op_reg == OP_ADD) && !hit_found && !full;
    assign ctl.rem_en = (state_reg == S_APPLY) && (op_reg == OP_REMOVE) && hit_found;

    // Row of cells, each taking its right neighbor's key on a remove
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nb_data;
        if (i == DEPTH - 1)
        begin : g_last
            assign nb_data = cell_data[i];
        end
        else
        begin : g_mid
            assign nb_data = cell_data[i + 1];
        end

        okst_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .key       (cell_key),
            .used      (used_reg),
            .hit_idx   (hit_idx),
            .next_data (nb_data),
            .data      (cell_data[i]),
            .match     (cell_match[i])
        );
    end

    okst_hit_enc #(
        .DEPTH (DEPTH)
    ) u_enc (
        .clk     (clk),
        .match   (cell_match),
        .found   (hit_found),
        .hit_idx (hit_idx)
    );

    // Read select, gated by position in range
    assign pos_wide  = PW'(pos_reg);
    assign used_wide = PW'(used_reg);
    assign pos_ok    = (pos_wide < PW'(DEPTH)) && (pos_wide < used_wide);
    assign rd_data   = cell_data[pos_wide[IdxW-1:0]];

    // Advance the sequencer and build the result
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        cnt_wide   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ENC;
                end
            end
            S_ENC:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (ctl.add_en)
                begin
                    used_next = used_reg + CntW'(1);
                end
                else if (ctl.rem_en)
                begin
                    used_next = used_reg - CntW'(1);
                end
                cnt_wide            = PW'(used_next);
                rsp_next.found      = hit_found;
                rsp_next.count      = cnt_wide[CNT_W-1:0];
                rsp_next.read_value = '0;
                rsp_next.status     = ST_OK;
                if ((op_reg == OP_ADD) && !hit_found && full)
                begin
                    rsp_next.status = ST_FULL;
                end
                if (op_reg == OP_READ)
                begin
                    if (pos_ok)
                    begin
                        rsp_next.read_value = rd_data;
                    end
                    else
                    begin
                        rsp_next.status = ST_BAD_POS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            op_reg  <= cmd.op;
            key_reg <= cmd.key;
            pos_reg <= cmd.position;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_IMPLY(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while busy")
    `ASSERT_CLK(a_used_bound, used_reg <= CntW'(DEPTH), "count above depth")
    `ASSERT_CLK(a_latency, accept |-> ##3 done_reg, "result missing three cycles after start")
    `ASSERT_IMPLY(a_full_flag, done_reg && (rsp_reg.status == ST_FULL), full, "full flag with room")
    `ASSERT_IMPLY(a_bad_pos_zero, done_reg && (rsp_reg.status == ST_BAD_POS),
        rsp_reg.read_value == '0, "bad read returned data")

endmodule
